// ----- design/stp_pkg.sv -----
// Shared types and constants for the stepper ramp and homing core.
package stp_pkg;

    localparam int POS_BITS  = 16;
    localparam int FRAC_BITS = 8;
    localparam int RATE_W    = 16 + FRAC_BITS;
    localparam int NUM_W     = 20 + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int JRN_W     = 15;

    localparam logic [15:0]      RESET_RATE  = 16'd600;
    localparam logic [15:0]      RESET_MAX   = 16'hFFFF;
    localparam logic [JRN_W-1:0] JOURNEY_MAX = {JRN_W{1'b1}};

    typedef enum logic [1:0] {
        OP_MOVE   = 2'd0,
        OP_TICK   = 2'd1,
        OP_ORIGIN = 2'd2,
        OP_LIMIT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_START_RATE  = 2'd0,
        CFG_TARGET_RATE = 2'd1,
        CFG_MAX_RATE    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] offset;
    } stp_cmd_t;

    typedef struct packed {
        logic [15:0]        rate_out;
        logic               rate_changed;
        logic               moving;
        logic               move_ended;
        logic               direction;
        logic signed [15:0] position;
        logic signed [15:0] axis_width;
        logic               home_known;
        logic               width_known;
    } stp_res_t;

endpackage

// ----- design/stp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp step.
module stp_div
    import stp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [JRN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [JRN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [JRN_W-1:0] den_reg, den_next;
    logic [JRN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg[JRN_W-1:0], quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit and subtract when it fits
            rem_next = fits ? shifted - {1'b0, den_reg} : shifted;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- design/stepper_trapezoid_ramp_homing_core.sv -----
// Stepper trapezoid ramp and homing core: command sequencer and state.
//
//   channel | signals                  | direction | payload
//   cmd     | cmd_valid / cmd_ready    | in        | stp_cmd_t (operation, offset)
//   res     | res_valid / res_ready    | out       | stp_res_t (one per command)
//   cfg     | cfg_we, cfg_index        | in        | cfg_data, 16 bits, write only
//
// Ticks, switch presses and ignored moves finish in the accepting cycle; the result is
// registered and shown the cycle after the transaction.
// A move with target_rate above start_rate runs the divider over all NUM_W (28)
// quotient bits and then clamps to max_rate; no new command is taken until then.
// A pending result blocks new commands until res_ready takes it.
// Reset (rst_n, asynchronous) restores the register defaults and idles the axis.
module stepper_trapezoid_ramp_homing_core
    import stp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  stp_cmd_t    cmd,
    output logic        res_valid,
    input  logic        res_ready,
    output stp_res_t    res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t              state_reg, state_next;
    logic [15:0]         start_rate_reg, start_rate_next;
    logic [15:0]         target_rate_reg, target_rate_next;
    logic [15:0]         max_rate_reg, max_rate_next;
    logic                busy_reg, busy_next;
    logic                dir_reg, dir_next;
    logic                home_reg, home_next;
    logic                width_flag_reg, width_flag_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [15:0]         width_reg, width_next;
    logic [JRN_W-1:0]    steps_left_reg, steps_left_next;
    logic [JRN_W-1:0]    journey_reg, journey_next;
    logic [RATE_W-1:0]   rate_now_reg, rate_now_next;
    logic [RATE_W-1:0]   ramp_step_reg, ramp_step_next;
    logic [RATE_W-1:0]   lim_reg, lim_next;
    logic                res_valid_reg, res_valid_next;
    stp_res_t            res_reg, res_next;

    logic             accept;
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quo;
    logic [15:0]      off_u;
    logic [15:0]      mag;
    logic [JRN_W-1:0] mag_sat;
    logic [15:0]      rate_diff;
    logic [19:0]      diff10;
    logic [JRN_W-1:0] steps_dec;
    logic [JRN_W+3:0] steps10;
    logic [JRN_W+3:0] journey9;
    logic [RATE_W:0]  rate_sum;
    logic             changed;
    logic             ended;
    logic [15:0]      rate_issue;

    assign cmd_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;

    assign off_u     = cmd.offset;
    assign mag       = off_u[15] ? 16'(~off_u + 16'd1) : off_u;
    assign mag_sat   = mag[15] ? JOURNEY_MAX : mag[JRN_W-1:0];
    assign rate_diff = target_rate_reg - start_rate_reg;
    assign diff10    = {1'b0, rate_diff, 3'b000} + {3'b000, rate_diff, 1'b0};
    assign div_num   = {diff10, {FRAC_BITS{1'b0}}};

    // ramp windows: first tenth and last tenth of the journey
    assign steps_dec = steps_left_reg - 1'b1;
    assign steps10   = {1'b0, steps_dec, 3'b000} + {3'b000, steps_dec, 1'b0};
    assign journey9  = {1'b0, journey_reg, 3'b000} + {4'b0000, journey_reg};
    assign rate_sum  = {1'b0, rate_now_reg} + {1'b0, ramp_step_reg};

    stp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (mag_sat),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next       = state_reg;
        start_rate_next  = start_rate_reg;
        target_rate_next = target_rate_reg;
        max_rate_next    = max_rate_reg;
        busy_next        = busy_reg;
        dir_next         = dir_reg;
        home_next        = home_reg;
        width_flag_next  = width_flag_reg;
        pos_next         = pos_reg;
        width_next       = width_reg;
        steps_left_next  = steps_left_reg;
        journey_next     = journey_reg;
        rate_now_next    = rate_now_reg;
        ramp_step_next   = ramp_step_reg;
        lim_next         = lim_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;
        div_start        = 1'b0;
        changed          = 1'b0;
        ended            = 1'b0;
        rate_issue       = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_RATE:  start_rate_next  = cfg_data;
                CFG_TARGET_RATE: target_rate_next = cfg_data;
                CFG_MAX_RATE:    max_rate_next    = cfg_data;
                default:         ;
            endcase
        end

        if (state_reg == ST_DIV && div_done)
        begin
            // clamp the quotient to max_rate
            ramp_step_next = (div_quo > NUM_W'(lim_reg)) ? lim_reg : div_quo[RATE_W-1:0];
            state_next     = ST_IDLE;
        end

        if (accept)
        begin
            case (cmd.operation)
                OP_MOVE:
                begin
                    if (!busy_reg && off_u != '0)
                    begin
                        dir_next        = !off_u[15];
                        journey_next    = mag_sat;
                        steps_left_next = mag_sat;
                        rate_now_next   = {start_rate_reg, {FRAC_BITS{1'b0}}};
                        lim_next        = {max_rate_reg, {FRAC_BITS{1'b0}}};
                        busy_next       = 1'b1;
                        changed         = 1'b1;
                        rate_issue      = start_rate_reg;
                        if (target_rate_reg > start_rate_reg)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            ramp_step_next = '0;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        pos_next        = dir_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                        steps_left_next = steps_dec;
                        if (steps_dec == '0)
                        begin
                            busy_next = 1'b0;
                            ended     = 1'b1;
                        end
                        else if (steps10 >= journey9)
                        begin
                            rate_now_next = rate_sum[RATE_W] ? {RATE_W{1'b1}}
                                                             : rate_sum[RATE_W-1:0];
                            changed       = 1'b1;
                            rate_issue    = rate_now_next[RATE_W-1:FRAC_BITS];
                        end
                        else if (steps10 <= {4'b0000, journey_reg})
                        begin
                            rate_now_next = (rate_now_reg > ramp_step_reg)
                                          ? rate_now_reg - ramp_step_reg : '0;
                            changed       = 1'b1;
                            rate_issue    = rate_now_next[RATE_W-1:FRAC_BITS];
                        end
                    end
                end
                OP_ORIGIN:
                begin
                    ended     = busy_reg;
                    busy_next = 1'b0;
                    if (!home_reg)
                    begin
                        home_next = 1'b1;
                        pos_next  = '0;
                    end
                end
                OP_LIMIT:
                begin
                    ended     = busy_reg;
                    busy_next = 1'b0;
                    if (home_reg && !width_flag_reg)
                    begin
                        width_flag_next = 1'b1;
                        width_next      = 16'(pos_reg);
                    end
                    else if (!home_reg && width_flag_reg)
                    begin
                        home_next = 1'b1;
                        pos_next  = POS_BITS'(width_reg);
                    end
                end
                default: ;
            endcase

            res_valid_next        = 1'b1;
            res_next.rate_out     = rate_issue;
            res_next.rate_changed = changed;
            res_next.moving       = busy_next;
            res_next.move_ended   = ended;
            res_next.direction    = dir_next;
            res_next.position     = 16'(pos_next);
            res_next.axis_width   = width_next;
            res_next.home_known   = home_next;
            res_next.width_known  = width_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            start_rate_reg  <= RESET_RATE;
            target_rate_reg <= RESET_RATE;
            max_rate_reg    <= RESET_MAX;
            busy_reg        <= 1'b0;
            dir_reg         <= 1'b0;
            home_reg        <= 1'b0;
            width_flag_reg  <= 1'b0;
            pos_reg         <= '0;
            width_reg       <= '0;
            steps_left_reg  <= '0;
            journey_reg     <= '0;
            rate_now_reg    <= {RESET_RATE, {FRAC_BITS{1'b0}}};
            ramp_step_reg   <= '0;
            lim_reg         <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            start_rate_reg  <= start_rate_next;
            target_rate_reg <= target_rate_next;
            max_rate_reg    <= max_rate_next;
            busy_reg        <= busy_next;
            dir_reg         <= dir_next;
            home_reg        <= home_next;
            width_flag_reg  <= width_flag_next;
            pos_reg         <= pos_next;
            width_reg       <= width_next;
            steps_left_reg  <= steps_left_next;
            journey_reg     <= journey_next;
            rate_now_reg    <= rate_now_next;
            ramp_step_reg   <= ramp_step_next;
            lim_reg         <= lim_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> steps_left_reg != '0)
        else $error("move in progress with no steps left");

    a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.move_ended |-> !res_reg.moving)
        else $error("result reports an ended move that is still moving");

    a_rate_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.rate_changed |-> res_reg.rate_out == '0)
        else $error("rate issued without rate_changed");

    a_step_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && div_done |=> ramp_step_reg <= lim_reg)
        else $error("ramp step above the clamp");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the stepper trapezoid ramp and homing core.
`timescale 1ns / 1ps

module tb;
    import stp_pkg::*;

    localparam int unsigned LONG_HOLD = 400;
    localparam logic [RATE_W-1:0] RATE_TOP = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    stp_cmd_t    cmd = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    stp_res_t    res;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_START_RATE;
    logic [15:0] cfg_data = '0;

    stp_cmd_t cmd_backlog[$];
    stp_res_t status_due[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        pressure_go = 1'b0;
    int unsigned hold_count = 0;
    int          error_count = 0;

    // shadow of the axis state and the rate registers
    logic [15:0]       rate_start = RESET_RATE;
    logic [15:0]       rate_target = RESET_RATE;
    logic [15:0]       rate_max = RESET_MAX;
    logic              ax_busy = 1'b0;
    logic              ax_dir = 1'b0;
    logic [15:0]       ax_pos = '0;
    logic [JRN_W-1:0]  ax_left = '0;
    logic [JRN_W-1:0]  ax_journey = '0;
    logic [RATE_W-1:0] ax_rate = RATE_W'(RESET_RATE) << FRAC_BITS;
    logic [RATE_W-1:0] ax_step = '0;
    logic              home_flag = 1'b0;
    logic              width_flag = 1'b0;
    logic [15:0]       width_reg = '0;

    stepper_trapezoid_ramp_homing_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic stp_res_t profile_step(stp_cmd_t c);
        stp_res_t    r;
        logic [16:0] mag;
        logic [63:0] num;
        logic [63:0] lim;
        logic [63:0] ext;
        logic        changed;
        logic        ended;
        logic [15:0] issue;
        changed = 1'b0;
        ended = 1'b0;
        issue = '0;
        case (c.operation)
            OP_MOVE:
                if (!ax_busy && c.offset != 0)
                begin
                    if (c.offset[15])
                    begin
                        ax_dir = 1'b0;
                        mag = 17'h10000 - {1'b0, c.offset};
                    end
                    else
                    begin
                        ax_dir = 1'b1;
                        mag = {1'b0, c.offset};
                    end
                    if (mag > 17'(JOURNEY_MAX))
                        mag = 17'(JOURNEY_MAX);
                    ax_journey = mag[JRN_W-1:0];
                    ax_left = mag[JRN_W-1:0];
                    if (rate_target > rate_start)
                    begin
                        num = ((64'(rate_target) - 64'(rate_start)) * 64'd10) << FRAC_BITS;
                        lim = 64'(rate_max) << FRAC_BITS;
                        ext = num / 64'(ax_journey);
                        if (ext > lim)
                            ext = lim;
                        ax_step = ext[RATE_W-1:0];
                    end
                    else
                        ax_step = '0;
                    ax_rate = RATE_W'(rate_start) << FRAC_BITS;
                    ax_busy = 1'b1;
                    changed = 1'b1;
                    issue = rate_start;
                end
            OP_TICK:
                if (ax_busy)
                begin
                    ax_pos = ax_dir ? ax_pos + 16'd1 : ax_pos - 16'd1;
                    ax_left = ax_left - 1'b1;
                    if (ax_left == 0)
                    begin
                        ended = 1'b1;
                        ax_busy = 1'b0;
                    end
                    else if (64'(ax_left) * 10 >= 64'(ax_journey) * 9)
                    begin
                        ext = 64'(ax_rate) + 64'(ax_step);
                        ax_rate = (ext > 64'(RATE_TOP)) ? RATE_TOP : ext[RATE_W-1:0];
                        changed = 1'b1;
                        issue = 16'(ax_rate >> FRAC_BITS);
                    end
                    else if (64'(ax_left) * 10 <= 64'(ax_journey))
                    begin
                        ax_rate = (ax_rate > ax_step) ? ax_rate - ax_step : '0;
                        changed = 1'b1;
                        issue = 16'(ax_rate >> FRAC_BITS);
                    end
                end
            OP_ORIGIN:
            begin
                ended = ax_busy;
                ax_busy = 1'b0;
                if (!home_flag)
                begin
                    home_flag = 1'b1;
                    ax_pos = '0;
                end
            end
            OP_LIMIT:
            begin
                ended = ax_busy;
                ax_busy = 1'b0;
                if (home_flag && !width_flag)
                begin
                    width_flag = 1'b1;
                    width_reg = ax_pos;
                end
                else if (!home_flag && width_flag)
                begin
                    home_flag = 1'b1;
                    ax_pos = width_reg;
                end
            end
            default: ;
        endcase
        r.rate_out = changed ? issue : '0;
        r.rate_changed = changed;
        r.moving = ax_busy;
        r.move_ended = ended;
        r.direction = ax_dir;
        r.position = ax_pos;
        r.axis_width = width_reg;
        r.home_known = home_flag;
        r.width_known = width_flag;
        return r;
    endfunction

    function automatic string show(stp_res_t r);
        return $sformatf({"rate=%0d chg=%0b mov=%0b end=%0b dir=%0b",
                          " pos=%0d width=%0d home=%0b wk=%0b"},
                         r.rate_out, r.rate_changed, r.moving, r.move_ended, r.direction,
                         r.position, r.axis_width, r.home_known, r.width_known);
    endfunction

    function automatic void enqueue(op_t op, logic [15:0] off);
        stp_cmd_t c;
        c.operation = op;
        c.offset = off;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endfunction

    // Driver: predict on every accepted command, then offer the next one.
    always @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            status_due.insert(status_due.size(), profile_step(cmd));
        if (!cmd_valid || cmd_ready)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd <= cmd_backlog.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Long receiver hold-off for the back-pressure phase.
    always @(posedge clk)
    begin
        if (pressure_go && hold_count < LONG_HOLD)
            hold_count <= hold_count + 1;
    end

    // Monitor: check each result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        stp_res_t want;
        if (res_valid && res_ready)
        begin
            if (status_due.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: %s", show(res));
            end
            else
            begin
                want = status_due.pop_front();
                if (res !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch expected: %s", show(want));
                        $display("         actual:   %s", show(res));
                    end
                end
            end
        end
        if (pressure_go && hold_count < LONG_HOLD)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic program_rates(logic [15:0] s, logic [15:0] t, logic [15:0] m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_RATE;
        cfg_data <= s;
        @(posedge clk);
        cfg_index <= CFG_TARGET_RATE;
        cfg_data <= t;
        @(posedge clk);
        cfg_index <= CFG_MAX_RATE;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate_start = s;
        rate_target = t;
        rate_max = m;
    endtask

    task automatic drain();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || status_due.size() != 0)
            @(negedge clk);
    endtask

    // Mostly complete moves with random content, some cut short by a switch,
    // plus a little noise.
    task automatic queue_traffic(int unsigned n_items);
        int unsigned added;
        int unsigned pick;
        int unsigned mag;
        int unsigned ticks;
        logic [15:0] off;
        added = 0;
        while (added < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                enqueue(op_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            else
            begin
                if (pick < 12)
                    mag = 32768;
                else if (pick < 22)
                    mag = $urandom_range(1, 32767);
                else
                    mag = $urandom_range(1, 40);
                off = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                if (mag == 32768)
                    off = 16'h8000;
                ticks = (mag > 48) ? $urandom_range(0, 48) : mag;
                if ($urandom_range(0, 9) == 0)
                    ticks = $urandom_range(0, ticks);
                enqueue(OP_MOVE, off);
                for (int i = 0; i < ticks; i++)
                    enqueue(OP_TICK, 16'($urandom_range(0, 65535)));
                added += 1 + ticks;
                if (ticks < mag)
                begin
                    enqueue(op_t'($urandom_range(0, 1) ? OP_ORIGIN : OP_LIMIT),
                            16'($urandom_range(0, 65535)));
                    added++;
                end
            end
        end
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                             int unsigned n_items);
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_traffic(n_items);
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        program_rates(16'd50, 16'd2000, 16'hFFFF);

        @(negedge clk);
        enqueue(OP_LIMIT, 16'h0000);    // no home, no width: nothing recorded
        enqueue(OP_TICK, 16'hFFFF);     // idle tick is ignored
        enqueue(OP_ORIGIN, 16'h7FFF);   // find home while idle
        enqueue(OP_MOVE, 16'h0000);     // zero offset is ignored
        enqueue(OP_MOVE, 16'd10);
        enqueue(OP_MOVE, 16'hFFFB);     // busy: ignored
        for (int i = 0; i < 10; i++)
            enqueue(OP_TICK, 16'h0000);
        enqueue(OP_MOVE, 16'h8000);     // journey saturates
        enqueue(OP_TICK, 16'h8000);
        enqueue(OP_TICK, 16'h0001);
        enqueue(OP_LIMIT, 16'h0000);    // stops the move, records width
        enqueue(OP_MOVE, 16'h7FFF);
        enqueue(OP_ORIGIN, 16'h0000);   // home already known: position kept
        enqueue(OP_MOVE, 16'hFFFF);
        enqueue(OP_TICK, 16'h0000);
        drain();

        program_rates(16'd0, 16'hFFFF, 16'hFFFF);
        run_phase(0, 0, 140);
        program_rates(16'd100, 16'd3000, 16'd50);
        run_phase(47, 0, 140);
        program_rates(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
        run_phase(0, 47, 140);
        program_rates(16'hFFFF, 16'd0, 16'd0);
        run_phase(19, 19, 140);
        program_rates(16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 65535)),
                      16'($urandom_range(1, 65535)));
        @(negedge clk);
        pressure_go = 1'b1;
        run_phase(0, 0, 140);

        repeat (40) @(posedge clk);
        if (error_count == 0 && status_due.size() == 0)
            $display("PASS stepper_trapezoid_ramp_homing_core");
        else
            $display("FAIL stepper_trapezoid_ramp_homing_core");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL stepper_trapezoid_ramp_homing_core");
        $finish;
    end

endmodule
